/* sv/fdc_pkg.sv */
package fdc_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int NUM_CHANNELS = 2;
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int OUT_BITS   = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ACC_W      = 64;
  localparam int MUL_W      = 40;

  localparam logic [CFG_IDX_W-1:0] REG_CLIP_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MK_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GATE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIX       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILT_G    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILT_H    = 3'd6;

  localparam logic [1:0] CLIP_HARD = 2'd0;
  localparam logic [1:0] CLIP_TANH = 2'd1;
  localparam logic [1:0] CLIP_ASYM = 2'd2;

  localparam logic signed [ACC_W-1:0] SQRT2_Q23 = 64'sd11863283;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GAIN, ST_CLIP, ST_TANH, ST_T, ST_HP, ST_A, ST_B, ST_WET,
    ST_MIX0, ST_MIX1, ST_DONE
  } state_e;

  typedef struct packed {
    logic               start;
    logic signed [MUL_W-1:0] a;
    logic        [23:0] b;
  } mul_req_t;

  function automatic logic [22:0] tanh_entry(input logic [5:0] k);
    logic [22:0] r;
    case (k)
      6'd0: r = 23'd0;        6'd1: r = 23'd1043149;  6'd2: r = 23'd2054527;
      6'd3: r = 23'd3006120;  6'd4: r = 23'd3876520;  6'd5: r = 23'd4652320;
      6'd6: r = 23'd5328016;  6'd7: r = 23'd5904788;  6'd8: r = 23'd6388715;
      6'd9: r = 23'd6788908;  6'd10: r = 23'd7116919; 6'd11: r = 23'd7380521;
      6'd12: r = 23'd7592934; 6'd13: r = 23'd7762367; 6'd14: r = 23'd7896830;
      6'd15: r = 23'd8003112; 6'd16: r = 23'd8086850; 6'd17: r = 23'd8152660;
      6'd18: r = 23'd8204278; 6'd19: r = 23'd8244702; 6'd20: r = 23'd8276321;
      6'd21: r = 23'd8301029; 6'd22: r = 23'd8320322; 6'd23: r = 23'd8335379;
      6'd24: r = 23'd8347124; 6'd25: r = 23'd8356283; 6'd26: r = 23'd8363422;
      6'd27: r = 23'd8368987; 6'd28: r = 23'd8373323; 6'd29: r = 23'd8376702;
      6'd30: r = 23'd8379334; 6'd31: r = 23'd8381385;
      default: r = 23'd8382981;
    endcase
    return r;
  endfunction

endpackage

/* sv/fdc_serial_mul.sv */
// Shift-add multiplier: signed a times unsigned 24-bit b, one bit of b per cycle.
module fdc_serial_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fdc_pkg::mul_req_t              req_i,
  output logic                           done_o,
  output logic signed [fdc_pkg::ACC_W-1:0] prod_o
);
  import fdc_pkg::*;

  logic signed [ACC_W-1:0] mcand_q, mcand_d, acc_q, acc_d;
  logic [23:0] mplier_q, mplier_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;

  always_comb begin
    mcand_d  = mcand_q;
    acc_d    = acc_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (req_i.start) begin
      mcand_d  = ACC_W'(req_i.a);
      mplier_d = req_i.b;
      acc_d    = '0;
      cnt_d    = '0;
      busy_d   = 1'b1;
    end else if (busy_q) begin
      if (mplier_q[0]) acc_d = acc_q + mcand_q;
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + 5'd1;
      if (cnt_q == 5'd23) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    acc_q    <= acc_d;
    mplier_q <= mplier_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule

/* sv/fuzz_distortion_channel_core.sv */
// Channel     | Handshake                | Payload
// ------------+--------------------------+-------------------------------------
// input       | in_valid_i / in_ready_o  | sample_in_i[23:0], channel_sel_i
// output      | out_valid_o / out_ready_i| sample_out_o[25:0]
// config      | cfg_valid_i / cfg_ready_o| cfg_index_i[2:0], cfg_data_i[31:0]
//
// One sample at a time. Every product goes through one shared bit-serial
// multiplier. A filtered tanh or asymmetric beat takes 10 products, or 9 when
// the tanh saturates or an asymmetric gained sample is not positive; a
// hard-clipped filtered beat 9 products; a gated beat 2 products.
// Reset clears registers to their defaults and both channels' integrators.
// The result sits in an output register; a new beat is taken once it is gone.
module fuzz_distortion_channel_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [fdc_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic                                channel_sel_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [fdc_pkg::OUT_BITS-1:0] sample_out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fdc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fdc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import fdc_pkg::*;

  // configuration
  logic [1:0]  clip_q;
  logic [14:0] igain_q;
  logic [15:0] mkgain_q, mix_q;
  logic [19:0] gate_q;
  logic [22:0] fg_q, fh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q   <= 2'd0;
      igain_q  <= 15'd12800;
      mkgain_q <= 16'd4634;
      gate_q   <= 20'd0;
      mix_q    <= 16'd32768;
      fg_q     <= 23'd1384959;
      fh_q     <= 23'd6653000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CLIP_MODE: clip_q   <= cfg_data_i[1:0];
        REG_IN_GAIN:   igain_q  <= cfg_data_i[14:0];
        REG_MK_GAIN:   mkgain_q <= cfg_data_i[15:0];
        REG_GATE:      gate_q   <= cfg_data_i[19:0];
        REG_MIX:       mix_q    <= cfg_data_i[15:0];
        REG_FILT_G:    fg_q     <= cfg_data_i[22:0];
        REG_FILT_H:    fh_q     <= cfg_data_i[22:0];
        default: ;
      endcase
    end
  end

  // integrator state, Q8.23
  logic signed [31:0] s1_q [NUM_CHANNELS];
  logic signed [31:0] s2_q [NUM_CHANNELS];

  state_e state_q, state_d;
  logic signed [SAMPLE_BITS-1:0] dry_q;
  logic [CH_W-1:0] ch_q;
  logic            filt_q;   // channel has a filter
  logic            gated_q;
  logic signed [ACC_W-1:0] v_q, v_d;     // general working value
  logic signed [ACC_W-1:0] c_q, c_d;     // clipped / lp
  logic signed [ACC_W-1:0] bp_q, bp_d;
  logic signed [ACC_W-1:0] wet_q, wet_d;
  logic [27:0] frac_q, frac_d;
  logic        neg_q, neg_d;
  logic [2:0]  sub_q, sub_d;             // product step within a state
  logic signed [OUT_BITS-1:0] res_q;
  logic        oval_q;

  mul_req_t req;
  logic     mdone;
  logic signed [ACC_W-1:0] prod;

  fdc_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .done_o (mdone),
    .prod_o (prod)
  );

  function automatic logic signed [ACC_W-1:0] sat64(input logic signed [ACC_W-1:0] x,
                                                     input logic signed [ACC_W-1:0] lo,
                                                     input logic signed [ACC_W-1:0] hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  localparam logic signed [ACC_W-1:0] I32MAX = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] I32MIN = -64'sd2147483648;

  logic signed [ACC_W-1:0] s1_64, s2_64;
  logic [23:0] gain_eff, mix_eff, mix_inv;
  logic [SAMPLE_BITS-1:0] mag;
  logic [ACC_W-1:0] u_abs;
  logic [5:0] tidx;
  logic [22:0] t0, t1;
  logic        ch_ok;
  logic        s_we;
  logic signed [31:0] s1_new, s2_new;

  assign s1_64 = ACC_W'(s1_q[ch_q]);
  assign s2_64 = ACC_W'(s2_q[ch_q]);
  assign gain_eff = (igain_q < 15'd256) ? 24'd256 : 24'(igain_q);
  assign mix_eff  = (mix_q > 16'd32768) ? 24'd32768 : 24'(mix_q);
  assign mix_inv  = 24'd32768 - mix_eff;
  assign mag = sample_in_i[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_in_i)
                                          : SAMPLE_BITS'(sample_in_i);
  assign ch_ok = (32'(channel_sel_i) < NUM_CHANNELS);
  assign u_abs = v_q[ACC_W-1] ? ACC_W'(-v_q) : ACC_W'(v_q);
  assign tidx  = (u_abs[ACC_W-1:33] != '0) ? 6'd32 : 6'(u_abs[32:28]);
  assign t0 = tanh_entry(tidx);
  assign t1 = tanh_entry(tidx + 6'd1);

  assign in_ready_o  = (state_q == ST_IDLE) && !oval_q;
  assign out_valid_o = oval_q;
  assign sample_out_o = res_q;

  always_comb begin
    state_d = state_q;
    v_d = v_q; c_d = c_q; bp_d = bp_q; wet_d = wet_q;
    frac_d = frac_q; neg_d = neg_q; sub_d = sub_q;
    req = '{start: 1'b0, a: '0, b: '0};
    s_we = 1'b0; s1_new = '0; s2_new = '0;
    unique case (state_q)
      ST_IDLE: ;
      ST_GAIN: begin
        wet_d = '0;
        if (gated_q) state_d = ST_MIX0;
        else begin
          req = '{start: 1'b1, a: MUL_W'(dry_q), b: gain_eff};
          state_d = ST_CLIP;
        end
      end
      ST_CLIP: if (mdone) begin
        if (clip_q == CLIP_TANH) begin
          v_d = prod; state_d = ST_TANH;
        end else if (clip_q == CLIP_ASYM && prod > 0) begin
          v_d = (prod * 3) >>> 1; state_d = ST_TANH;  // positive: floor == trunc
        end else begin
          c_d = sat64(prod, -(64'sd1 <<< 31), 64'sd1 <<< 31) >>> 8;
          state_d = ST_T;
        end
        sub_d = '0;
      end
      ST_TANH: begin
        if (sub_q == 3'd0) begin
          neg_d = v_q[ACC_W-1];
          frac_d = u_abs[27:0];
          if (tidx == 6'd32) begin
            c_d = v_q[ACC_W-1] ? -ACC_W'(t0) : ACC_W'(t0);
            state_d = ST_T;
          end else begin
            c_d = ACC_W'(t0);
            req = '{start: 1'b1, a: MUL_W'(frac_q), b: 24'(t1 - t0)};
            req.a = MUL_W'(u_abs[27:0]);
            sub_d = 3'd1;
          end
        end else if (mdone) begin
          c_d = neg_q ? -(c_q + (prod >>> 28)) : (c_q + (prod >>> 28));
          sub_d = '0;
          state_d = ST_T;
        end
      end
      ST_T: begin
        // t = s1*(g+sqrt2) done as s1*g + s1*sqrt2 (two products)
        if (!filt_q) begin
          req = '{start: 1'b1, a: MUL_W'(c_q), b: 24'(mkgain_q)};
          state_d = ST_WET;
        end else if (sub_q == 3'd0) begin
          req = '{start: 1'b1, a: MUL_W'(s1_64), b: 24'(fg_q)};
          sub_d = 3'd1;
        end else if (sub_q == 3'd1 && mdone) begin
          v_d = prod;
          req = '{start: 1'b1, a: MUL_W'(s1_64), b: 24'(SQRT2_Q23)};
          sub_d = 3'd2;
        end else if (sub_q == 3'd2 && mdone) begin
          v_d = sat64(c_q - ((v_q + prod) >>> 23) - s2_64,
                      -(64'sd1 <<< 33), 64'sd1 <<< 33);
          sub_d = 3'd0;
          state_d = ST_HP;
        end
      end
      ST_HP: begin
        if (sub_q == 3'd0) begin
          req = '{start: 1'b1, a: MUL_W'(v_q), b: 24'(fh_q)};
          sub_d = 3'd1;
        end else if (mdone) begin
          req = '{start: 1'b1, a: MUL_W'(prod >>> 23), b: 24'(fg_q)};
          sub_d = 3'd0;
          state_d = ST_A;
        end
      end
      ST_A: if (mdone) begin
        bp_d = (prod >>> 23) + s1_64;
        v_d  = sat64((prod >>> 23) + (prod >>> 23) + s1_64, I32MIN, I32MAX);
        req = '{start: 1'b1, a: MUL_W'((prod >>> 23) + s1_64), b: 24'(fg_q)};
        state_d = ST_B;
      end
      ST_B: if (mdone) begin
        s_we = 1'b1;
        s1_new = v_q[31:0];
        s2_new = 32'(sat64((prod >>> 23) + (prod >>> 23) + s2_64, I32MIN, I32MAX));
        c_d = sat64((prod >>> 23) + s2_64, I32MIN, I32MAX);
        req = '{start: 1'b1, a: MUL_W'(sat64((prod >>> 23) + s2_64, I32MIN, I32MAX)),
                b: 24'(mkgain_q)};
        state_d = ST_WET;
      end
      ST_WET: if (mdone) begin
        wet_d = prod >>> 14;
        state_d = ST_MIX0;
      end
      ST_MIX0: begin
        if (sub_q == 3'd0) begin
          req = '{start: 1'b1, a: MUL_W'(dry_q), b: mix_inv};
          sub_d = 3'd1;
        end else if (sub_q == 3'd1 && mdone) begin
          v_d = prod;
          req = '{start: 1'b1, a: MUL_W'(wet_q), b: mix_eff};
          sub_d = 3'd0;
          state_d = ST_MIX1;
        end
      end
      ST_MIX1: if (mdone) begin
        v_d = sat64((v_q + prod) >>> 15, -64'sd33554432, 64'sd33554431);
        state_d = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      oval_q  <= 1'b0;
      sub_q   <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        s1_q[i] <= '0;
        s2_q[i] <= '0;
      end
    end else begin
      sub_q <= sub_d;
      if (s_we) begin
        s1_q[ch_q] <= s1_new;
        s2_q[ch_q] <= s2_new;
      end
      if (in_valid_i && in_ready_o) state_q <= ST_GAIN;
      else state_q <= state_d;
      if (state_q == ST_DONE) oval_q <= 1'b1;
      else if (out_ready_i) oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; c_q <= c_d; bp_q <= bp_d; wet_q <= wet_d;
    frac_q <= frac_d; neg_q <= neg_d;
    if (in_valid_i && in_ready_o) begin
      dry_q   <= sample_in_i;
      ch_q    <= CH_W'(channel_sel_i);
      filt_q  <= ch_ok;
      gated_q <= (32'(mag) < 32'(gate_q));
    end
    if (state_q == ST_DONE) res_q <= v_q[OUT_BITS-1:0];
  end
endmodule
